// ----- hdl/sms_pkg.sv -----
// Shared types, constants and field layout for the stepper move sequencer.
package sms_pkg;

	// Field widths of the stream items and configuration registers
	localparam int unsigned CMD_W        = 3;
	localparam int unsigned MM_W         = 12;
	localparam int unsigned DUR_W        = 16;
	localparam int unsigned PERIOD_W     = 32;
	localparam int unsigned HALF_W       = 31;
	localparam int unsigned STEPS_W      = 20;
	localparam int unsigned SPM_W        = 8;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 12;
	localparam int unsigned IN_DATA_W    = 80;
	localparam int unsigned OUT_PAYLOAD_W = 81;
	localparam int unsigned OUT_DATA_W   = 88;

	// Divider geometry: dividend is duration * 1e6, divisor is track * steps_per_mm
	localparam int unsigned DIVIDEND_W   = 36;
	localparam int unsigned DIVISOR_W    = 20;
	localparam int unsigned DIV_CNT_W    = $clog2(DIVIDEND_W);

	// Constants of the motion scheme
	localparam logic [PERIOD_W-1:0] FIXED_STEP_US  = 32'd600;
	localparam logic [DIVIDEND_W-1:0] US_PER_S     = 36'd1000000;
	localparam logic [DUR_W-1:0]    DURATION_RESET = 16'd10;
	localparam logic [SPM_W-1:0]    SPM_RESET      = 8'd75;
	localparam logic [MM_W-1:0]     TRACK_RESET    = 12'd240;

	// Command codes carried in tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_SET_TARGET = 3'd1,
		CMD_TIMED      = 3'd2,
		CMD_SET_LOOP   = 3'd3,
		CMD_SET_RUN    = 3'd4,
		CMD_SET_POS    = 3'd5,
		CMD_SET_STEP   = 3'd6,
		CMD_CLEAR_FIN  = 3'd7
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEPS_PER_MM = 1'd0,
		CFG_TRACK_LEN    = 1'd1
	} cfg_idx_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_OUT  = 5'b10000
	} ctrl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic div_start;
		logic finish;
		logic out_load;
	} sms_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic tm_req;
		logic div_done;
		logic out_full;
	} sms_stat_t;

endpackage

// ----- hdl/sms_div.sv -----
// Restoring divider, one quotient bit per cycle, for the timed step period.
module sms_div import sms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// Trial subtraction of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	assign done     = busy_q && (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1));
	assign quotient = quo_q;

	// Step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

endmodule

// ----- hdl/sms_datapath.sv -----
// Datapath: configuration, motion state, timed-period divider and result register.
module sms_datapath import sms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CMD_W-1:0]      s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  sms_cmd_t              cmd,
	output sms_stat_t             stat
);

	// Configuration registers
	logic [SPM_W-1:0]     spm_q;
	logic [MM_W-1:0]      track_q;
	logic [DIVISOR_W-1:0] divisor_q;

	// Captured input item
	logic [CMD_W-1:0]    in_cmd_q;
	logic [MM_W-1:0]     in_target_q;
	logic [DUR_W-1:0]    in_dur_q;
	logic                in_flag_q;
	logic [MM_W-1:0]     in_pos_q;
	logic [PERIOD_W-1:0] in_step_q;

	// Motion state
	logic [MM_W-1:0]     position_q;
	logic [MM_W-1:0]     target_q;
	logic [STEPS_W-1:0]  steps_left_q;
	logic [DUR_W-1:0]    duration_q;
	logic [PERIOD_W-1:0] step_period_q;
	logic                running_q;
	logic                finished_q;
	logic                forward_q;
	logic                looping_q;
	logic                pulse_q;

	// Pending timed move
	logic [MM_W-1:0] tm_tgt_q;
	logic            tm_loop_q;

	// Result register
	logic                     out_valid_q;
	logic [OUT_PAYLOAD_W-1:0] out_data_q;

	logic                  tick_step;
	logic [STEPS_W-1:0]    left_dec;
	logic                  arrive;
	logic                  tm_req;
	logic [DUR_W-1:0]      tm_dur;
	logic [MM_W-1:0]       tm_tgt;
	logic                  tm_loop;
	logic [DIVIDEND_W-1:0] dividend;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic [PERIOD_W-1:0]   timed_period;
	logic [MM_W-1:0]       aim_tgt;
	logic                  aim_fwd;
	logic [MM_W-1:0]       aim_dist;
	logic [STEPS_W-1:0]    aim_steps;
	cmd_t                  cur_cmd;

	assign cur_cmd = cmd_t'(in_cmd_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q   <= SPM_RESET;
			track_q <= TRACK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STEPS_PER_MM: spm_q   <= cfg_data[SPM_W-1:0];
				CFG_TRACK_LEN:    track_q <= cfg_data[MM_W-1:0];
				default:          ;
			endcase
		end
	end

	// Timing divisor follows the configuration
	always_ff @(posedge clk) begin
		divisor_q <= DIVISOR_W'(track_q) * DIVISOR_W'(spm_q);
	end

	// Input capture on an accepted transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_cmd_q    <= s_tuser;
			in_target_q <= s_tdata[11:0];
			in_dur_q    <= s_tdata[27:12];
			in_flag_q   <= s_tdata[28];
			in_pos_q    <= s_tdata[40:29];
			in_step_q   <= s_tdata[72:41];
		end
	end

	// Tick decode: a step is taken while running and off target
	assign tick_step = running_q && (position_q != target_q);
	assign left_dec  = (steps_left_q == '0) ? '0 : steps_left_q - 1'b1;
	assign arrive    = tick_step && (left_dec == '0);

	// Decide whether this item starts a timed move, and with what arguments
	always_comb begin
		tm_req  = 1'b0;
		tm_dur  = duration_q;
		tm_tgt  = track_q;
		tm_loop = 1'b0;
		unique case (cur_cmd)
			CMD_TICK: begin
				if (arrive && looping_q && (target_q == track_q || target_q == '0)) begin
					tm_req  = 1'b1;
					tm_tgt  = (target_q == track_q) ? '0 : track_q;
					tm_loop = 1'b1;
				end
			end
			CMD_TIMED: begin
				tm_req = 1'b1;
				tm_dur = in_dur_q;
				tm_tgt = in_target_q;
			end
			CMD_SET_LOOP: begin
				tm_req  = 1'b1;
				tm_loop = in_flag_q;
			end
			default: ;
		endcase
	end

	assign dividend = DIVIDEND_W'(tm_dur) * US_PER_S;

	sms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// A zero divisor or a quotient beyond 32 bits saturates the period
	assign timed_period = (divisor_q == '0 || quotient[DIVIDEND_W-1:PERIOD_W] != '0)
		? '1 : quotient[PERIOD_W-1:0];

	// Aiming: direction and step count toward a new target
	assign aim_tgt   = cmd.finish ? tm_tgt_q : in_target_q;
	assign aim_fwd   = aim_tgt >= position_q;
	assign aim_dist  = aim_fwd ? aim_tgt - position_q : position_q - aim_tgt;
	assign aim_steps = STEPS_W'(aim_dist) * STEPS_W'(spm_q);

	// Motion state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			target_q      <= '0;
			steps_left_q  <= '0;
			duration_q    <= DURATION_RESET;
			step_period_q <= FIXED_STEP_US;
			running_q     <= 1'b0;
			finished_q    <= 1'b0;
			forward_q     <= 1'b1;
			looping_q     <= 1'b0;
			pulse_q       <= 1'b0;
		end else if (cmd.exec) begin
			pulse_q <= 1'b0;
			if (tm_req) begin
				duration_q <= tm_dur;
			end
			unique case (cur_cmd)
				CMD_TICK: begin
					if (tick_step) begin
						pulse_q      <= 1'b1;
						steps_left_q <= left_dec;
						if (arrive) begin
							position_q <= target_q;
							if (!tm_req) begin
								running_q  <= 1'b0;
								finished_q <= 1'b1;
							end
						end
					end
				end
				CMD_SET_TARGET: begin
					step_period_q <= FIXED_STEP_US;
					target_q      <= aim_tgt;
					forward_q     <= aim_fwd;
					steps_left_q  <= aim_steps;
					looping_q     <= 1'b0;
				end
				CMD_SET_RUN:   running_q     <= in_flag_q;
				CMD_SET_POS:   position_q    <= in_pos_q;
				CMD_SET_STEP:  step_period_q <= in_step_q;
				CMD_CLEAR_FIN: finished_q    <= 1'b0;
				default: ;
			endcase
		end else if (cmd.finish) begin
			step_period_q <= timed_period;
			target_q      <= aim_tgt;
			forward_q     <= aim_fwd;
			steps_left_q  <= aim_steps;
			looping_q     <= tm_loop_q;
		end
	end

	// Timed move arguments held through the division
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			tm_tgt_q  <= tm_tgt;
			tm_loop_q <= tm_loop;
		end
	end

	// Result register: holds one result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {looping_q, finished_q, running_q, steps_left_q, target_q,
				position_q, step_period_q[PERIOD_W-1:1], ~pulse_q, forward_q, pulse_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_PAYLOAD_W)'(0), out_data_q};

	assign stat.tm_req   = tm_req;
	assign stat.div_done = div_done;
	assign stat.out_full = out_valid_q;

endmodule

// ----- hdl/sms_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module sms_ctrl import sms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      m_tready,
	input  sms_stat_t stat,
	output sms_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.div_start = stat.tm_req;
				state_d       = stat.tm_req ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_full || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// ----- hdl/stepper_move_sequencer_top.sv -----
// Each item passes the IDLE, EXEC and OUT states, one item at a time; an item that
// recomputes the step period also passes DIV and FIN, waiting on the 36-step restoring
// divider that produces one quotient bit per cycle. OUT waits while a result is untaken.
// A new input is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) restores the configuration and motion state defaults
// and empties the output register.
module stepper_move_sequencer_top import sms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cmd
	input  logic [CMD_W-1:0]      s_tuser,
	// target_mm, duration_s, flag, position_mm, step_time_us, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// step_pulse, dir_out, enable_n, half_period_us, cur_position, cur_target,
	// steps_remaining, is_running, is_finished, loop_on, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	sms_cmd_t  dp_cmd;
	sms_stat_t dp_stat;

	sms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	sms_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in work");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!dp_stat.out_full || m_tready))
		else $error("result register overwritten before transfer");

	// The divider only starts while an item executes.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.div_start |-> (dp_cmd.exec && !s_tready))
		else $error("divider started outside item execution");

	// Division completes only while the input side is closed.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.div_done |-> !s_tready)
		else $error("divider finished while idle");

endmodule
